// ----- rtl/core/rap_pkg.sv -----
// Shared constants and types for the Euler rotation pipeline.
package rap_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned TRIG_FRAC_DEF   = 15;
  localparam int unsigned ANGLE_W         = 16;

  // Internal trig arithmetic is Q2.30
  localparam int unsigned QS     = 30;
  localparam int unsigned QONE   = 32'd1 << QS;
  localparam int unsigned XW     = 31;  // reduced angle in radians, unsigned
  localparam int unsigned X2W    = 32;  // x^2 >> 30
  localparam int unsigned SERW   = 31;  // series term, [0, 1.0]
  localparam int unsigned RW     = 13;  // remainder within a quadrant

  // 360 and 90 degrees in 1/64 degree
  localparam int FULL_TURN    = 23040;
  localparam int QUARTER_TURN = 5760;

  // pi/2 in Q2.30 split as HP_QUO * 5760 + HP_REM
  localparam int unsigned HP_QUO = 292817;
  localparam int unsigned HP_REM = 3793;
  localparam int unsigned HP_RND = 2880;

  // x / 5760 = (x >> 7) / 45, reciprocal with one-step fixup
  localparam int unsigned REM_SHIFT = 7;
  localparam int unsigned DIV45     = 45;
  localparam int unsigned DIV45_MUL = 372828;
  localparam int unsigned DIV45_SH  = 24;

  localparam int unsigned SIN_STEPS = 5;
  localparam int unsigned COS_STEPS = 6;
  localparam int unsigned SIN_DIV [SIN_STEPS] = '{110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [COS_STEPS] = '{132, 90, 56, 30, 12, 2};

  localparam int unsigned TRIG_LAT = 24;
  localparam int unsigned TURN_LAT = 4;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } rap_quad_e;

endpackage

// ----- rtl/core/euler_rotate_about_pivot.sv -----
// Euler rotation of a 3D point about a pivot: yaw (x-z), pitch (y-z), roll (x-y).
//
// Fully pipelined: one point per clock while the skid register is empty. The
// sine/cosine series of all three angles run in parallel, then the yaw, pitch
// and roll plane rotations in turn, then the output register. The
// longest part is the Taylor series: six Horner steps for cosine, each a
// multiply, a reciprocal multiply and a fixup register. A skid register at
// the output lets the pipeline finish its current request while the
// consumer stalls; in_ready_o drops only when that skid register is full,
// and then the whole pipeline holds. An axis whose raw angle is zero passes
// its coordinates untouched; all written coordinates saturate to
// COORD_WIDTH bits.
module euler_rotate_about_pivot #(
  parameter int unsigned COORD_WIDTH    = rap_pkg::COORD_WIDTH_DEF,
  parameter int unsigned TRIG_FRAC_BITS = rap_pkg::TRIG_FRAC_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]      coord_x_i,
  input  logic signed [COORD_WIDTH-1:0]      coord_y_i,
  input  logic signed [COORD_WIDTH-1:0]      coord_z_i,
  input  logic signed [COORD_WIDTH-1:0]      center_x_i,
  input  logic signed [COORD_WIDTH-1:0]      center_y_i,
  input  logic signed [COORD_WIDTH-1:0]      center_z_i,
  input  logic signed [rap_pkg::ANGLE_W-1:0] yaw_angle_i,
  input  logic signed [rap_pkg::ANGLE_W-1:0] pitch_angle_i,
  input  logic signed [rap_pkg::ANGLE_W-1:0] roll_angle_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [COORD_WIDTH-1:0]      rotated_x_o,
  output logic signed [COORD_WIDTH-1:0]      rotated_y_o,
  output logic signed [COORD_WIDTH-1:0]      rotated_z_o
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned TW  = TRIG_FRAC_BITS + 2;
  localparam int unsigned NST = rap_pkg::TRIG_LAT + 3 * rap_pkg::TURN_LAT;
  localparam int unsigned D0W = 6 * CW + 3;
  localparam int unsigned D1W = 4 * CW + 4 * TW + 2;
  localparam int unsigned D2W = 3 * CW + 2 * TW + 1;

  logic            en;
  logic            vld_q [NST];
  logic            out_v_q, skid_v_q, out_free;
  logic [3*CW-1:0] last_data, out_q, skid_q;

  // pipeline stalls only while the skid register holds a request
  assign en         = !skid_v_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < NST; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // --- sine/cosine of all three angles -------------------------------------
  logic signed [TW-1:0] ys, yc, ps, pc, rs, rc;

  rap_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_yaw (
    .clk_i(clk_i), .en_i(en), .angle_i(yaw_angle_i), .sin_o(ys), .cos_o(yc)
  );
  rap_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_pitch (
    .clk_i(clk_i), .en_i(en), .angle_i(pitch_angle_i), .sin_o(ps), .cos_o(pc)
  );
  rap_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_roll (
    .clk_i(clk_i), .en_i(en), .angle_i(roll_angle_i), .sin_o(rs), .cos_o(rc)
  );

  // point, pivot and zero-angle flags ride alongside the trig units
  logic [D0W-1:0]       d0_in, d0_out;
  logic signed [CW-1:0] x0, y0, z0, cx0, cy0, cz0;
  logic                 yz0, pz0, rz0;

  assign d0_in = {coord_x_i, coord_y_i, coord_z_i, center_x_i, center_y_i, center_z_i,
                  yaw_angle_i == '0, pitch_angle_i == '0, roll_angle_i == '0};

  rap_delay #(.WIDTH(D0W), .DEPTH(rap_pkg::TRIG_LAT)) u_d0 (
    .clk_i(clk_i), .en_i(en), .d_i(d0_in), .q_o(d0_out)
  );
  assign {x0, y0, z0, cx0, cy0, cz0, yz0, pz0, rz0} = d0_out;

  // --- yaw: x-z plane ------------------------------------------------------
  logic signed [CW-1:0] x1, z1, y1, cx1, cy1, cz1;
  logic signed [TW-1:0] ps1, pc1, rs1, rc1;
  logic                 pz1, rz1;
  logic [D1W-1:0]       d1_out;

  rap_turn #(.COORD_WIDTH(CW), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_yaw (
    .clk_i(clk_i), .en_i(en), .u_i(x0), .v_i(z0), .cu_i(cx0), .cv_i(cz0),
    .sin_i(ys), .cos_i(yc), .skip_i(yz0), .u_o(x1), .v_o(z1)
  );

  rap_delay #(.WIDTH(D1W), .DEPTH(rap_pkg::TURN_LAT)) u_d1 (
    .clk_i(clk_i), .en_i(en),
    .d_i({y0, cx0, cy0, cz0, ps, pc, rs, rc, pz0, rz0}), .q_o(d1_out)
  );
  assign {y1, cx1, cy1, cz1, ps1, pc1, rs1, rc1, pz1, rz1} = d1_out;

  // --- pitch: y-z plane ----------------------------------------------------
  logic signed [CW-1:0] y2, z2, x2, cx2, cy2;
  logic signed [TW-1:0] rs2, rc2;
  logic                 rz2;
  logic [D2W-1:0]       d2_out;

  rap_turn #(.COORD_WIDTH(CW), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_pitch (
    .clk_i(clk_i), .en_i(en), .u_i(y1), .v_i(z1), .cu_i(cy1), .cv_i(cz1),
    .sin_i(ps1), .cos_i(pc1), .skip_i(pz1), .u_o(y2), .v_o(z2)
  );

  rap_delay #(.WIDTH(D2W), .DEPTH(rap_pkg::TURN_LAT)) u_d2 (
    .clk_i(clk_i), .en_i(en),
    .d_i({x1, cx1, cy1, rs1, rc1, rz1}), .q_o(d2_out)
  );
  assign {x2, cx2, cy2, rs2, rc2, rz2} = d2_out;

  // --- roll: x-y plane (y plays u, x plays v) ------------------------------
  logic signed [CW-1:0] x3, y3, z3;

  rap_turn #(.COORD_WIDTH(CW), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_roll (
    .clk_i(clk_i), .en_i(en), .u_i(y2), .v_i(x2), .cu_i(cy2), .cv_i(cx2),
    .sin_i(rs2), .cos_i(rc2), .skip_i(rz2), .u_o(y3), .v_o(x3)
  );

  rap_delay #(.WIDTH(CW), .DEPTH(rap_pkg::TURN_LAT)) u_d3 (
    .clk_i(clk_i), .en_i(en), .d_i(z2), .q_o(z3)
  );

  assign last_data = {x3, y3, z3};

  // --- output register with skid ------------------------------------------
  assign out_free = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_free) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (out_free) begin
      out_v_q <= vld_q[NST-1];
    end else if (vld_q[NST-1]) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (out_free) begin
      out_q <= last_data;
    end else if (vld_q[NST-1]) begin
      skid_q <= last_data;
    end
  end

  assign out_valid_o = out_v_q;
  assign rotated_x_o = out_q[3*CW-1:2*CW];
  assign rotated_y_o = out_q[2*CW-1:CW];
  assign rotated_z_o = out_q[CW-1:0];

`ifndef SYNTHESIS
  a_skid_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a request while output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid filled without an output stall");

  a_pipe_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> $stable(vld_q[NST-1]))
    else $error("pipeline moved while skid was full");
`endif

endmodule

// ----- rtl/core/rap_delay.sv -----
// Enabled shift-register delay line.
module rap_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

// ----- rtl/core/rap_step.sv -----
// One Horner step of the trig series: t' = max(0, 1 - (x2*t >> 30) / DIVISOR).
module rap_step #(
  parameter int unsigned DIVISOR = 2
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [rap_pkg::X2W-1:0]    x2_i,
  input  logic [rap_pkg::SERW-1:0]   t_i,
  output logic [rap_pkg::X2W-1:0]    x2_o,
  output logic [rap_pkg::SERW-1:0]   t_o
);

  // ceil(2^32 / DIVISOR): quotient estimate is exact or one high
  localparam logic [32:0] RECIP =
    33'(((64'd1 << 32) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
  localparam logic [7:0] DIV_C = 8'(DIVISOR);

  logic [rap_pkg::X2W-1:0]  x2a_q, x2b_q, x2c_q;
  logic [31:0]              p_q, p2_q, q0_q;
  logic [rap_pkg::SERW-1:0] t_q;
  logic [62:0]              xt_prod;
  logic [64:0]              rc_prod;
  logic [39:0]              back;
  logic [31:0]              quo;
  logic [rap_pkg::SERW-1:0] t_d;

  assign xt_prod = 63'(x2_i) * 63'(t_i);
  assign rc_prod = 65'(p_q) * 65'(RECIP);
  assign back    = 40'(q0_q) * 40'(DIV_C);

  always_comb begin
    quo = (back > 40'(p2_q)) ? q0_q - 32'd1 : q0_q;
    if (quo > 32'(rap_pkg::QONE)) begin
      t_d = '0;
    end else begin
      t_d = rap_pkg::SERW'(32'(rap_pkg::QONE) - quo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= xt_prod[61:30];
      x2a_q <= x2_i;
      q0_q  <= rc_prod[63:32];
      p2_q  <= p_q;
      x2b_q <= x2a_q;
      t_q   <= t_d;
      x2c_q <= x2b_q;
    end
  end

  assign x2_o = x2c_q;
  assign t_o  = t_q;

endmodule

// ----- rtl/core/rap_trig.sv -----
// Pipelined sine/cosine of an angle in 1/64 degree, Taylor series in Q2.30.
module rap_trig #(
  parameter  int unsigned TRIG_FRAC_BITS = rap_pkg::TRIG_FRAC_DEF,
  localparam int unsigned TW             = TRIG_FRAC_BITS + 2
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [rap_pkg::ANGLE_W-1:0] angle_i,
  output logic signed [TW-1:0]               sin_o,
  output logic signed [TW-1:0]               cos_o
);

  localparam int unsigned SH = rap_pkg::QS - TRIG_FRAC_BITS;
  localparam logic [32:0] RND = 33'(1) << (SH - 1);
  localparam logic signed [17:0] FT = 18'(rap_pkg::FULL_TURN);
  localparam logic signed [17:0] QT = 18'(rap_pkg::QUARTER_TURN);
  localparam int unsigned MW = 25;
  localparam int unsigned NW = 18;

  logic signed [17:0]         ang_ext, red;
  rap_pkg::rap_quad_e         quad_d;
  logic [rap_pkg::RW-1:0]     rem_d;

  rap_pkg::rap_quad_e         q1_q, q2_q, q3_q, q4_q, q5_q, qd;
  logic [1:0]                 qd_raw;
  logic [rap_pkg::RW-1:0]     r1_q, qq0_q, qq;
  logic [rap_pkg::XW-1:0]     a2_q, a3_q, x4_q, x5_q, xd;
  logic [MW-1:0]              m2_q;
  logic [NW-1:0]              n3_q;
  logic [36:0]                n_prod;
  logic [18:0]                qq_back;
  logic [61:0]                xx_prod, xt_prod;
  logic [rap_pkg::X2W-1:0]    x2_q;
  logic [31:0]                sp_q, sp_dly;
  logic [TW-1:0]              s_r, c_r;
  logic signed [TW-1:0]       sin_d, cos_d, sin_q, cos_q;

  logic [rap_pkg::X2W-1:0]    sx2 [rap_pkg::SIN_STEPS];
  logic [rap_pkg::SERW-1:0]   st  [rap_pkg::SIN_STEPS+1];
  logic [rap_pkg::X2W-1:0]    cx2 [rap_pkg::COS_STEPS];
  logic [rap_pkg::SERW-1:0]   ct  [rap_pkg::COS_STEPS+1];

  // angle mod 360 into [0, 23040), then quadrant and remainder
  always_comb begin
    ang_ext = 18'(angle_i);
    if (ang_ext < -FT) begin
      red = ang_ext + FT + FT;
    end else if (ang_ext < 18'sd0) begin
      red = ang_ext + FT;
    end else if (ang_ext >= FT) begin
      red = ang_ext - FT;
    end else begin
      red = ang_ext;
    end
    if (red >= QT + QT + QT) begin
      quad_d = rap_pkg::QUAD_3;
      rem_d  = rap_pkg::RW'(red - QT - QT - QT);
    end else if (red >= QT + QT) begin
      quad_d = rap_pkg::QUAD_2;
      rem_d  = rap_pkg::RW'(red - QT - QT);
    end else if (red >= QT) begin
      quad_d = rap_pkg::QUAD_1;
      rem_d  = rap_pkg::RW'(red - QT);
    end else begin
      quad_d = rap_pkg::QUAD_0;
      rem_d  = rap_pkg::RW'(red);
    end
  end

  assign n_prod  = 37'(m2_q[MW-1:rap_pkg::REM_SHIFT]) * 37'(rap_pkg::DIV45_MUL);
  assign qq_back = 19'(qq0_q) * 19'(rap_pkg::DIV45);
  assign qq      = (qq_back > 19'(n3_q)) ? qq0_q - rap_pkg::RW'(1) : qq0_q;
  assign xx_prod = 62'(x4_q) * 62'(x4_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q1_q  <= quad_d;
      r1_q  <= rem_d;
      q2_q  <= q1_q;
      a2_q  <= rap_pkg::XW'(32'(r1_q) * 32'(rap_pkg::HP_QUO));
      m2_q  <= MW'(32'(r1_q) * 32'(rap_pkg::HP_REM) + 32'(rap_pkg::HP_RND));
      q3_q  <= q2_q;
      a3_q  <= a2_q;
      n3_q  <= m2_q[MW-1:rap_pkg::REM_SHIFT];
      qq0_q <= n_prod[rap_pkg::DIV45_SH +: rap_pkg::RW];
      q4_q  <= q3_q;
      x4_q  <= a3_q + rap_pkg::XW'(qq);
      q5_q  <= q4_q;
      x5_q  <= x4_q;
      x2_q  <= xx_prod[61:30];
    end
  end

  // series chains
  assign st[0] = rap_pkg::SERW'(rap_pkg::QONE);
  assign ct[0] = rap_pkg::SERW'(rap_pkg::QONE);
  assign sx2[0] = x2_q;
  assign cx2[0] = x2_q;

  for (genvar i = 0; i < rap_pkg::SIN_STEPS; i++) begin : g_sin
    if (i < rap_pkg::SIN_STEPS - 1) begin : g_mid
      rap_step #(.DIVISOR(rap_pkg::SIN_DIV[i])) u_step (
        .clk_i(clk_i), .en_i(en_i), .x2_i(sx2[i]), .t_i(st[i]),
        .x2_o(sx2[i+1]), .t_o(st[i+1])
      );
    end else begin : g_last
      rap_step #(.DIVISOR(rap_pkg::SIN_DIV[i])) u_step (
        .clk_i(clk_i), .en_i(en_i), .x2_i(sx2[i]), .t_i(st[i]),
        .x2_o(), .t_o(st[i+1])
      );
    end
  end

  for (genvar i = 0; i < rap_pkg::COS_STEPS; i++) begin : g_cos
    if (i < rap_pkg::COS_STEPS - 1) begin : g_mid
      rap_step #(.DIVISOR(rap_pkg::COS_DIV[i])) u_step (
        .clk_i(clk_i), .en_i(en_i), .x2_i(cx2[i]), .t_i(ct[i]),
        .x2_o(cx2[i+1]), .t_o(ct[i+1])
      );
    end else begin : g_last
      rap_step #(.DIVISOR(rap_pkg::COS_DIV[i])) u_step (
        .clk_i(clk_i), .en_i(en_i), .x2_i(cx2[i]), .t_i(ct[i]),
        .x2_o(), .t_o(ct[i+1])
      );
    end
  end

  rap_delay #(.WIDTH(rap_pkg::XW), .DEPTH(rap_pkg::SIN_STEPS * 3)) u_x_dly (
    .clk_i(clk_i), .en_i(en_i), .d_i(x5_q), .q_o(xd)
  );

  rap_delay #(.WIDTH(2), .DEPTH(rap_pkg::COS_STEPS * 3)) u_q_dly (
    .clk_i(clk_i), .en_i(en_i), .d_i(q5_q), .q_o(qd_raw)
  );
  assign qd = rap_pkg::rap_quad_e'(qd_raw);

  // sine = x * series
  assign xt_prod = 62'(xd) * 62'(st[rap_pkg::SIN_STEPS]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp_q <= xt_prod[61:30];
    end
  end

  rap_delay #(.WIDTH(32), .DEPTH((rap_pkg::COS_STEPS - rap_pkg::SIN_STEPS) * 3 - 1)) u_s_dly (
    .clk_i(clk_i), .en_i(en_i), .d_i(sp_q), .q_o(sp_dly)
  );

  // round to output fraction width, then unfold the quadrant
  always_comb begin
    s_r = TW'((33'(sp_dly) + RND) >> SH);
    c_r = TW'((33'(ct[rap_pkg::COS_STEPS]) + RND) >> SH);
    case (qd)
      rap_pkg::QUAD_0: begin
        sin_d = $signed(s_r);
        cos_d = $signed(c_r);
      end
      rap_pkg::QUAD_1: begin
        sin_d = $signed(c_r);
        cos_d = -$signed(s_r);
      end
      rap_pkg::QUAD_2: begin
        sin_d = -$signed(s_r);
        cos_d = -$signed(c_r);
      end
      default: begin
        sin_d = -$signed(c_r);
        cos_d = $signed(s_r);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ----- rtl/core/rap_turn.sv -----
// One plane rotation about the pivot: subtract, rotate, round, add back, saturate.
module rap_turn #(
  parameter  int unsigned COORD_WIDTH    = rap_pkg::COORD_WIDTH_DEF,
  parameter  int unsigned TRIG_FRAC_BITS = rap_pkg::TRIG_FRAC_DEF,
  localparam int unsigned TW             = TRIG_FRAC_BITS + 2
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [COORD_WIDTH-1:0] u_i,
  input  logic signed [COORD_WIDTH-1:0] v_i,
  input  logic signed [COORD_WIDTH-1:0] cu_i,
  input  logic signed [COORD_WIDTH-1:0] cv_i,
  input  logic signed [TW-1:0]          sin_i,
  input  logic signed [TW-1:0]          cos_i,
  input  logic                          skip_i,
  output logic signed [COORD_WIDTH-1:0] u_o,
  output logic signed [COORD_WIDTH-1:0] v_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned PW = DW + TW;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned HW = SW - TRIG_FRAC_BITS;
  localparam int unsigned AW = HW + 1;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (TRIG_FRAC_BITS - 1);
  localparam logic signed [AW-1:0] SMAX = (AW'(1) <<< (CW - 1)) - AW'(1);
  localparam logic signed [AW-1:0] SMIN = -SMAX - AW'(1);

  logic signed [CW-1:0] u1_q, v1_q, cu1_q, cv1_q;
  logic signed [CW-1:0] u2_q, v2_q, cu2_q, cv2_q;
  logic signed [CW-1:0] u3_q, v3_q, cu3_q, cv3_q;
  logic signed [CW-1:0] uo_q, vo_q;
  logic                 sk1_q, sk2_q, sk3_q;
  logic signed [TW-1:0] s1_q, c1_q;
  logic signed [DW-1:0] du_q, dv_q;
  logic signed [PW-1:0] pcu_q, psv_q, pcv_q, psu_q;
  logic signed [SW-1:0] su_q, sv_q;
  logic signed [AW-1:0] au, av;
  logic signed [CW-1:0] uo_d, vo_d;

  always_comb begin
    au = AW'($signed(su_q[SW-1:TRIG_FRAC_BITS])) + AW'(cu3_q);
    av = AW'($signed(sv_q[SW-1:TRIG_FRAC_BITS])) + AW'(cv3_q);
    if (sk3_q) begin
      uo_d = u3_q;
    end else if (au > SMAX) begin
      uo_d = CW'(SMAX);
    end else if (au < SMIN) begin
      uo_d = CW'(SMIN);
    end else begin
      uo_d = CW'(au);
    end
    if (sk3_q) begin
      vo_d = v3_q;
    end else if (av > SMAX) begin
      vo_d = CW'(SMAX);
    end else if (av < SMIN) begin
      vo_d = CW'(SMIN);
    end else begin
      vo_d = CW'(av);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // difference to pivot, one bit wider
      du_q  <= DW'(u_i) - DW'(cu_i);
      dv_q  <= DW'(v_i) - DW'(cv_i);
      s1_q  <= sin_i;
      c1_q  <= cos_i;
      u1_q  <= u_i;
      v1_q  <= v_i;
      cu1_q <= cu_i;
      cv1_q <= cv_i;
      sk1_q <= skip_i;
      // products
      pcu_q <= PW'(c1_q) * PW'(du_q);
      psv_q <= PW'(s1_q) * PW'(dv_q);
      pcv_q <= PW'(c1_q) * PW'(dv_q);
      psu_q <= PW'(s1_q) * PW'(du_q);
      u2_q  <= u1_q;
      v2_q  <= v1_q;
      cu2_q <= cu1_q;
      cv2_q <= cv1_q;
      sk2_q <= sk1_q;
      // sums with round-half-up offset
      su_q  <= SW'(pcu_q) - SW'(psv_q) + HALF;
      sv_q  <= SW'(pcv_q) + SW'(psu_q) + HALF;
      u3_q  <= u2_q;
      v3_q  <= v2_q;
      cu3_q <= cu2_q;
      cv3_q <= cv2_q;
      sk3_q <= sk2_q;
      // shift, add pivot, saturate
      uo_q  <= uo_d;
      vo_q  <= vo_d;
    end
  end

  assign u_o = uo_q;
  assign v_o = vo_q;

endmodule

// ----- verif/tb_euler_rotate_about_pivot.sv -----
// Testbench for the Euler rotation about a pivot: driver, monitor and bit-exact predictor.
module tb_euler_rotate_about_pivot;

  localparam int CW = 32;
  localparam int TF = 15;
  localparam int AW = rap_pkg::ANGLE_W;
  localparam int LATENCY = 37;

  typedef struct packed {
    logic signed [CW-1:0] px, py, pz, cx, cy, cz;
    logic signed [AW-1:0] yaw, pitch, roll;
  } point_req_t;

  typedef struct packed {
    logic signed [CW-1:0] x, y, z;
  } point_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CW-1:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic signed [CW-1:0] center_x_i = '0, center_y_i = '0, center_z_i = '0;
  logic signed [AW-1:0] yaw_angle_i = '0, pitch_angle_i = '0, roll_angle_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [CW-1:0] rotated_x_o, rotated_y_o, rotated_z_o;

  euler_rotate_about_pivot DUT (.*);

  initial forever #6 clk_i = ~clk_i;

  point_req_t pending_reqs[$];
  point_res_t expected_pts[$];
  int errors = 0;
  int n_sent = 0, n_checked = 0;
  bit stim_done = 0;
  bit no_idle = 0;
  bit drain_hold = 0;

  // Q2.30 helpers for the trig series
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> rap_pkg::QS;
  endfunction

  // Sine and cosine of an angle in 1/64 degree, both Q2.15
  function automatic void trig_of(input longint ang, output longint sn, output longint cs);
    longint a, q, r, x, x2, t, s, c;
    longint sd[5];
    longint cd[6];
    sd = '{110, 72, 42, 20, 6};
    cd = '{132, 90, 56, 30, 12, 2};
    a = ang % rap_pkg::FULL_TURN;
    if (a < 0) a += rap_pkg::FULL_TURN;
    q = a / rap_pkg::QUARTER_TURN;
    r = a % rap_pkg::QUARTER_TURN;
    x = (r * 64'sd1686629713 + rap_pkg::QUARTER_TURN / 2) / rap_pkg::QUARTER_TURN;
    x2 = qmul(x, x);
    t = longint'(1) << rap_pkg::QS;
    for (int i = 0; i < 5; i++) begin
      t = (longint'(1) << rap_pkg::QS) - qmul(x2, t) / sd[i];
      if (t < 0) t = 0;
    end
    s = (qmul(x, t) + (longint'(1) << (rap_pkg::QS - TF - 1))) >>> (rap_pkg::QS - TF);
    t = longint'(1) << rap_pkg::QS;
    for (int i = 0; i < 6; i++) begin
      t = (longint'(1) << rap_pkg::QS) - qmul(x2, t) / cd[i];
      if (t < 0) t = 0;
    end
    c = (t + (longint'(1) << (rap_pkg::QS - TF - 1))) >>> (rap_pkg::QS - TF);
    case (q)
      0: begin sn = s; cs = c; end
      1: begin sn = c; cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  // sat(round_half_up((c*u - s*v) / 2^TF) + pivot); products fit in 64 bits
  function automatic longint plane_turn(longint u, longint v, longint c, longint s,
                                        longint ctr);
    longint acc, hi, lo;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -hi - 1;
    acc = ((c * u - s * v + (longint'(1) << (TF - 1))) >>> TF) + ctr;
    if (acc > hi) return hi;
    if (acc < lo) return lo;
    return acc;
  endfunction

  function automatic point_res_t rotate_point(point_req_t r);
    longint x, y, z, cx, cy, cz, s, c, u, v;
    point_res_t res;
    x = r.px; y = r.py; z = r.pz; cx = r.cx; cy = r.cy; cz = r.cz;
    if (r.yaw != 0) begin
      trig_of(r.yaw, s, c);
      u = x - cx; v = z - cz;
      x = plane_turn(u, v, c, s, cx);
      z = plane_turn(v, u, c, -s, cz);
    end
    if (r.pitch != 0) begin
      trig_of(r.pitch, s, c);
      u = y - cy; v = z - cz;
      y = plane_turn(u, v, c, s, cy);
      z = plane_turn(v, u, c, -s, cz);
    end
    if (r.roll != 0) begin
      trig_of(r.roll, s, c);
      u = y - cy; v = x - cx;
      y = plane_turn(u, v, c, s, cy);
      x = plane_turn(v, u, c, -s, cx);
    end
    res.x = x[CW-1:0]; res.y = y[CW-1:0]; res.z = z[CW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_checked);
  endtask

  // Coordinates biased toward edges, small values and ordinary ranges
  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, {(CW-1){$urandom_range(0, 1) == 0}}};
      1: return $urandom;
      2: return CW'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return CW'(int'($urandom_range(0, 32'h3fff_ffff)) - 32'sh2000_0000);
    endcase
  endfunction

  function automatic logic [AW-1:0] rand_angle();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return AW'($urandom_range(0, 8) * rap_pkg::QUARTER_TURN);
      2: return AW'(-$signed(AW'($urandom_range(0, 5) * rap_pkg::QUARTER_TURN)));
      default: return AW'($urandom);
    endcase
  endfunction

  function automatic point_req_t mk(longint x, longint y, longint z, longint cx,
                                    longint cy, longint cz, int yw, int pt, int rl);
    point_req_t r;
    r.px = CW'(x); r.py = CW'(y); r.pz = CW'(z);
    r.cx = CW'(cx); r.cy = CW'(cy); r.cz = CW'(cz);
    r.yaw = AW'(yw); r.pitch = AW'(pt); r.roll = AW'(rl);
    return r;
  endfunction

  initial begin
    point_req_t r;
    longint mx, mn;
    mx = 64'sh7fff_ffff; mn = -64'sh8000_0000;
    // directed: all angles zero, each axis alone, quadrant edges, full turns,
    // negative wrap, angle extremes, saturation with extreme pivots
    pending_reqs.push_back(mk(mx, mn, 12345, 1, 2, 3, 0, 0, 0));
    pending_reqs.push_back(mk(65536, 0, 0, 0, 0, 0, 5760, 0, 0));
    pending_reqs.push_back(mk(0, 65536, 0, 0, 0, 0, 0, 5760, 0));
    pending_reqs.push_back(mk(65536, 0, 0, 0, 0, 0, 0, 0, 5760));
    pending_reqs.push_back(mk(65536, 2, 3, 0, 0, 0, 11520, 17280, 2880));
    pending_reqs.push_back(mk(mx, mx, mx, 0, 0, 0, 23040, 23040, 23040));
    pending_reqs.push_back(mk(mx, mn, mx, mn, mx, mn, 23040, -23040, 0));
    pending_reqs.push_back(mk(1, -1, 7, 0, 0, 0, -1, 1, -5760));
    pending_reqs.push_back(mk(mx, mx, mx, mn, mn, mn, 32767, -32768, 32767));
    pending_reqs.push_back(mk(mn, mn, mn, mx, mx, mx, 2880, 2880, 2880));
    pending_reqs.push_back(mk(mx, mn, 0, 0, 0, 0, 5759, 5761, 17279));
    pending_reqs.push_back(mk(-65536, 65536, -65536, 1 << 20, -(1 << 20), 0, 100, 200, 300));
    pending_reqs.push_back(mk(-1, -1, -1, -1, -1, -1, -32768, -32768, -32768));
    pending_reqs.push_back(mk(0, 0, 0, mx, mn, mx, 11520, 11520, 11520));
    for (int i = 0; i < 1350; i++) begin
      r = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           rand_coord(), rand_angle(), rand_angle(), rand_angle()};
      if ($urandom_range(0, 3) == 0) begin
        r.cx = '0; r.cy = '0; r.cz = '0;
      end
      pending_reqs.push_back(r);
    end
  end

  // driver
  int in_gap = 0;
  int pause_at = 700;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_pts.push_back(rotate_point({coord_x_i, coord_y_i, coord_z_i, center_x_i,
          center_y_i, center_z_i, yaw_angle_i, pitch_angle_i, roll_angle_i}));
        n_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (n_sent == pause_at && expected_pts.size() != 0) begin
          // hold off until the pipeline has fully drained
          in_valid_i <= 1'b0;
        end else if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          in_valid_i <= 1'b0;
          stim_done <= 1'b1;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 12) - 1;
          in_valid_i <= 1'b0;
        end else begin
          point_req_t r;
          r = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          {coord_x_i, coord_y_i, coord_z_i, center_x_i, center_y_i, center_z_i,
           yaw_angle_i, pitch_angle_i, roll_angle_i} <= r;
          if (pending_reqs.size() < 150) no_idle <= 1'b1;
        end
      end
    end
  end

  // monitor
  int out_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        point_res_t want;
        if (expected_pts.size() == 0) begin
          report_mismatch("unexpected x", rotated_x_o, '0);
        end else begin
          want = expected_pts.pop_front();
          if (rotated_x_o !== want.x) report_mismatch("x", rotated_x_o, want.x);
          if (rotated_y_o !== want.y) report_mismatch("y", rotated_y_o, want.y);
          if (rotated_z_o !== want.z) report_mismatch("z", rotated_z_o, want.z);
        end
        n_checked++;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        out_stall = $urandom_range(1, 12) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && expected_pts.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("covered %0d rotations: zero and full-turn angles, quadrant edges,", n_checked);
    $display("extreme pivots with saturation, random idling on both channels");
    if (errors == 0 && expected_pts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("timeout after %0d results", n_checked);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
